// File: rtl/sbba_pkg.sv
// Shared constants, kind codes and types for the surface bounding box accumulator.
// No dependencies; imported by sbba_cand, surface_bounding_box_accumulator, sbba_checker and testbench.
package sbba_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int PARAM_W         = 32;
	localparam int KIND_W          = 5;
	localparam int CNT_W           = 3;
	localparam int OUT_W           = 32;
	localparam int NUM_BOUNDS      = 6;

	// hexagon factor 1/sin60 as K / 2^30, rounded product
	localparam int            HEX_K_W   = 31;
	localparam logic [30:0]   HEX_K     = 31'd1239850262;
	localparam int            HEX_SHIFT = 30;
	localparam int            PROD_W    = PARAM_W + HEX_K_W;
	localparam int            HEX_W     = PROD_W - HEX_SHIFT;
	localparam int            OFF_W     = HEX_W + 1;
	localparam int            SUM_W     = OFF_W + 1;

	localparam logic [CNT_W-1:0] CAP_COUNT = 3'd5;
	localparam logic [CNT_W-1:0] ALT_COUNT = 3'd4;

	localparam logic [KIND_W-1:0] KIND_CYL_Z     = 5'd0;
	localparam logic [KIND_W-1:0] KIND_CYL_X     = 5'd1;
	localparam logic [KIND_W-1:0] KIND_CYL_Y     = 5'd2;
	localparam logic [KIND_W-1:0] KIND_CROSS     = 5'd3;
	localparam logic [KIND_W-1:0] KIND_SPHERE    = 5'd4;
	localparam logic [KIND_W-1:0] KIND_CUBOID    = 5'd5;
	localparam logic [KIND_W-1:0] KIND_RECT      = 5'd6;
	localparam logic [KIND_W-1:0] KIND_HEX_Y     = 5'd7;
	localparam logic [KIND_W-1:0] KIND_HEX_X     = 5'd8;
	localparam logic [KIND_W-1:0] KIND_HPRISM_Y  = 5'd9;
	localparam logic [KIND_W-1:0] KIND_HPRISM_X  = 5'd10;
	localparam logic [KIND_W-1:0] KIND_PLANE_X   = 5'd11;
	localparam logic [KIND_W-1:0] KIND_PLANE_Y   = 5'd12;
	localparam logic [KIND_W-1:0] KIND_PLANE_Z   = 5'd13;
	localparam logic [KIND_W-1:0] KIND_CAPCONE_X = 5'd14;
	localparam logic [KIND_W-1:0] KIND_CAPCONE_Y = 5'd15;
	localparam logic [KIND_W-1:0] KIND_CAPCONE_Z = 5'd16;
	localparam logic [KIND_W-1:0] KIND_CONE      = 5'd17;
	localparam logic [KIND_W-1:0] KIND_INFINITE  = 5'd18;
	localparam logic [KIND_W-1:0] KIND_PAD       = 5'd19;
	localparam logic [KIND_W-1:0] KIND_DODECA    = 5'd20;
	localparam logic [KIND_W-1:0] KIND_OCTAGON   = 5'd21;
	localparam logic [KIND_W-1:0] KIND_UNBOUNDED = 5'd22;
	localparam logic [KIND_W-1:0] KIND_GCROSS    = 5'd23;

	localparam int LX = 0;
	localparam int HX = 1;
	localparam int LY = 2;
	localparam int HY = 3;
	localparam int LZ = 4;
	localparam int HZ = 5;

	typedef struct packed {
		logic [NUM_BOUNDS-1:0] en;
		logic                  clear;
		logic                  bad;
	} sbba_ctl_t;

endpackage

// File: rtl/sbba_cand.sv
// Per-kind candidate bounds: picks centre and offset for each of the six bounds,
// adds and saturates to COORD_WIDTH. Depends on sbba_pkg.
module sbba_cand #(
	parameter int COORD_WIDTH = sbba_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  start_new,
	input  logic [sbba_pkg::KIND_W-1:0]           kind,
	input  logic [sbba_pkg::CNT_W-1:0]            cnt,
	input  logic signed [sbba_pkg::PARAM_W-1:0]   pa,
	input  logic signed [sbba_pkg::PARAM_W-1:0]   pb,
	input  logic signed [sbba_pkg::PARAM_W-1:0]   pc,
	input  logic signed [sbba_pkg::PARAM_W-1:0]   pd,
	input  logic signed [sbba_pkg::PARAM_W-1:0]   pe,
	input  logic signed [sbba_pkg::PARAM_W-1:0]   pf,
	input  logic signed [sbba_pkg::OFF_W-1:0]     hex_r,
	output sbba_pkg::sbba_ctl_t                   ctl,
	output logic signed [COORD_WIDTH-1:0]         cand [sbba_pkg::NUM_BOUNDS]
);
	import sbba_pkg::*;

	localparam int EW = (COORD_WIDTH > SUM_W) ? COORD_WIDTH : SUM_W;
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [EW-1:0] CMAX_E = EW'(CMAX);
	localparam logic signed [EW-1:0] CMIN_E = EW'(CMIN);

	logic signed [PARAM_W-1:0] ctr [NUM_BOUNDS];
	logic signed [OFF_W-1:0]   off [NUM_BOUNDS];
	logic [2:0]                sp_en;
	logic signed [PARAM_W-1:0] sp_c [3];
	logic signed [OFF_W-1:0]   sp_r [3];
	logic [NUM_BOUNDS-1:0]     en;
	logic                      bad;

	function automatic logic signed [OFF_W-1:0] wide(input logic signed [PARAM_W-1:0] v);
		wide = OFF_W'(v);
	endfunction

	always_comb begin
		en    = '0;
		bad   = 1'b0;
		sp_en = '0;
		for (int i = 0; i < NUM_BOUNDS; i++) begin
			ctr[i] = '0;
			off[i] = '0;
		end
		for (int j = 0; j < 3; j++) begin
			sp_c[j] = '0;
			sp_r[j] = '0;
		end
		unique case (kind)
			KIND_CYL_Z: begin
				sp_en = 3'b011;
				sp_c[0] = pa; sp_r[0] = wide(pc);
				sp_c[1] = pb; sp_r[1] = wide(pc);
				if (cnt == CAP_COUNT) begin
					ctr[LZ] = pd; ctr[HZ] = pe; en[LZ] = 1'b1; en[HZ] = 1'b1;
				end
			end
			KIND_CYL_X: begin
				sp_en = 3'b110;
				sp_c[1] = pa; sp_r[1] = wide(pc);
				sp_c[2] = pb; sp_r[2] = wide(pc);
				if (cnt == CAP_COUNT) begin
					ctr[LX] = pd; ctr[HX] = pe; en[LX] = 1'b1; en[HX] = 1'b1;
				end
			end
			KIND_CYL_Y: begin
				sp_en = 3'b101;
				sp_c[0] = pa; sp_r[0] = wide(pc);
				sp_c[2] = pb; sp_r[2] = wide(pc);
				if (cnt == CAP_COUNT) begin
					ctr[LY] = pd; ctr[HY] = pe; en[LY] = 1'b1; en[HY] = 1'b1;
				end
			end
			KIND_CROSS, KIND_PAD: begin
				sp_en = 3'b011;
				sp_c[0] = pa; sp_r[0] = wide(pd);
				sp_c[1] = pb; sp_r[1] = wide(pd);
			end
			KIND_SPHERE: begin
				sp_en = 3'b111;
				sp_c[0] = pa; sp_r[0] = wide(pd);
				sp_c[1] = pb; sp_r[1] = wide(pd);
				sp_c[2] = pc; sp_r[2] = wide(pd);
			end
			KIND_CUBOID: begin
				ctr[LX] = pa; ctr[HX] = pb; ctr[LY] = pc; ctr[HY] = pd;
				ctr[LZ] = pe; ctr[HZ] = pf;
				en = '1;
			end
			KIND_RECT: begin
				ctr[LX] = pa; ctr[HX] = pb; ctr[LY] = pc; ctr[HY] = pd;
				en[LX] = 1'b1; en[HX] = 1'b1; en[LY] = 1'b1; en[HY] = 1'b1;
			end
			KIND_HEX_Y, KIND_HPRISM_Y: begin
				sp_en = 3'b011;
				sp_c[0] = pa; sp_r[0] = hex_r;
				sp_c[1] = pb; sp_r[1] = wide(pc);
				if (kind == KIND_HPRISM_Y) begin
					ctr[LZ] = pd; ctr[HZ] = pe; en[LZ] = 1'b1; en[HZ] = 1'b1;
				end
			end
			KIND_HEX_X, KIND_HPRISM_X: begin
				sp_en = 3'b011;
				sp_c[1] = pa; sp_r[1] = hex_r;
				sp_c[0] = pb; sp_r[0] = wide(pc);
				if (kind == KIND_HPRISM_X) begin
					ctr[LZ] = pd; ctr[HZ] = pe; en[LZ] = 1'b1; en[HZ] = 1'b1;
				end
			end
			KIND_PLANE_X: begin
				ctr[LX] = pa; ctr[HX] = pa; en[LX] = 1'b1; en[HX] = 1'b1;
			end
			KIND_PLANE_Y: begin
				ctr[LY] = pa; ctr[HY] = pa; en[LY] = 1'b1; en[HY] = 1'b1;
			end
			KIND_PLANE_Z: begin
				ctr[LZ] = pa; ctr[HZ] = pa; en[LZ] = 1'b1; en[HZ] = 1'b1;
			end
			KIND_CAPCONE_X: begin
				ctr[LX] = pa; ctr[HX] = pa;
				if (cnt == CAP_COUNT) begin
					en[HX] = pe[PARAM_W-1];
					en[LX] = !pe[PARAM_W-1];
				end
			end
			KIND_CAPCONE_Y: begin
				ctr[LY] = pb; ctr[HY] = pb;
				if (cnt == CAP_COUNT) begin
					en[HY] = pe[PARAM_W-1];
					en[LY] = !pe[PARAM_W-1];
				end
			end
			KIND_CAPCONE_Z: begin
				ctr[LZ] = pc; ctr[HZ] = pc;
				if (cnt == CAP_COUNT) begin
					en[HZ] = pe[PARAM_W-1];
					en[LZ] = !pe[PARAM_W-1];
				end
			end
			KIND_CONE: begin
				ctr[LZ] = pc; off[LZ] = wide(pe);
				ctr[HZ] = pc; off[HZ] = wide(pe);
				en[HZ] = (pe > 0);
				en[LZ] = !(pe > 0);
			end
			KIND_INFINITE, KIND_UNBOUNDED: begin
			end
			KIND_DODECA: begin
				sp_en = 3'b011;
				sp_c[0] = pa; sp_r[0] = wide(pc);
				sp_c[1] = pb; sp_r[1] = (cnt == ALT_COUNT) ? wide(pd) : wide(pc);
			end
			KIND_OCTAGON, KIND_GCROSS: begin
				sp_en = 3'b011;
				sp_c[0] = pa; sp_r[0] = wide(pc);
				sp_c[1] = pb; sp_r[1] = wide(pc);
			end
			default: bad = 1'b1;
		endcase
		for (int j = 0; j < 3; j++) begin
			if (sp_en[j]) begin
				ctr[2*j]   = sp_c[j];
				off[2*j]   = -sp_r[j];
				ctr[2*j+1] = sp_c[j];
				off[2*j+1] = sp_r[j];
				en[2*j]    = 1'b1;
				en[2*j+1]  = 1'b1;
			end
		end
	end

	assign ctl.en    = en;
	assign ctl.bad   = bad;
	assign ctl.clear = !bad && (start_new || kind == KIND_INFINITE);

	for (genvar i = 0; i < NUM_BOUNDS; i++) begin : g_sat
		logic signed [SUM_W-1:0] sum;
		logic signed [EW-1:0]    sum_e;
		assign sum   = SUM_W'(ctr[i]) + SUM_W'(off[i]);
		assign sum_e = EW'(sum);
		assign cand[i] = (sum_e > CMAX_E) ? CMAX :
			(sum_e < CMIN_E) ? CMIN : COORD_WIDTH'(sum_e);
	end

endmodule

// File: rtl/surface_bounding_box_accumulator.sv
// Surface bounding box accumulator, top level. Depends on sbba_pkg and sbba_cand.
// A request passes the input register, then the hexagon multiply stage, then the box and
// result register on its way to a valid result.
// Throughput: one request per cycle while out_ready does not stall the result register, set by the
// compare-and-update loop on the six box bounds. Reset (arst_n low) empties the box and drops all requests in flight.
module surface_bounding_box_accumulator #(
	parameter int COORD_WIDTH = sbba_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                start_new,
	input  logic [sbba_pkg::KIND_W-1:0]         command,
	input  logic [sbba_pkg::CNT_W-1:0]          param_count,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_a,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_b,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_c,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_d,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_e,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_f,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sbba_pkg::OUT_W-1:0]   low_x,
	output logic signed [sbba_pkg::OUT_W-1:0]   high_x,
	output logic signed [sbba_pkg::OUT_W-1:0]   low_y,
	output logic signed [sbba_pkg::OUT_W-1:0]   high_y,
	output logic signed [sbba_pkg::OUT_W-1:0]   low_z,
	output logic signed [sbba_pkg::OUT_W-1:0]   high_z,
	output logic                                bad_kind
);
	import sbba_pkg::*;

	localparam int XW = (COORD_WIDTH > OUT_W) ? COORD_WIDTH : OUT_W;
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic                      v_s1, v_s2, out_valid_q;
	logic                      en_s1, en_s2, en_out, adv;
	logic                      start_s1, start_s2;
	logic [KIND_W-1:0]         kind_s1, kind_s2;
	logic [CNT_W-1:0]          cnt_s1, cnt_s2;
	logic signed [PARAM_W-1:0] a_s1, b_s1, c_s1, d_s1, e_s1, f_s1;
	logic signed [PARAM_W-1:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2;
	logic signed [OFF_W-1:0]   hex_s2;

	logic [PARAM_W-1:0]        hex_mag;
	logic [PROD_W-1:0]         hex_prod;
	logic [HEX_W-1:0]          hex_p;
	logic signed [OFF_W-1:0]   hex_r;

	sbba_ctl_t                     ctl;
	logic signed [COORD_WIDTH-1:0] cand   [NUM_BOUNDS];
	logic signed [COORD_WIDTH-1:0] box_q  [NUM_BOUNDS];
	logic signed [COORD_WIDTH-1:0] box_nx [NUM_BOUNDS];
	logic signed [OUT_W-1:0]       res_q  [NUM_BOUNDS];
	logic                          bad_q;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign adv      = v_s2 && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			start_s1 <= start_new;
			kind_s1  <= command;
			cnt_s1   <= param_count;
			a_s1     <= param_a;
			b_s1     <= param_b;
			c_s1     <= param_c;
			d_s1     <= param_d;
			e_s1     <= param_e;
			f_s1     <= param_f;
		end
	end

	// r / sin60, rounded to nearest, ties away from zero
	always_comb begin
		hex_mag  = c_s1[PARAM_W-1] ? (~c_s1 + 1'b1) : c_s1;
		hex_prod = PROD_W'(hex_mag) * PROD_W'(HEX_K);
		hex_prod = hex_prod + (PROD_W'(1) << (HEX_SHIFT - 1));
		hex_p    = hex_prod[PROD_W-1:HEX_SHIFT];
		hex_r    = c_s1[PARAM_W-1] ? -$signed(OFF_W'(hex_p)) : $signed(OFF_W'(hex_p));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			start_s2 <= start_s1;
			kind_s2  <= kind_s1;
			cnt_s2   <= cnt_s1;
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			c_s2     <= c_s1;
			d_s2     <= d_s1;
			e_s2     <= e_s1;
			f_s2     <= f_s1;
			hex_s2   <= hex_r;
		end
	end

	sbba_cand #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_cand (
		.start_new(start_s2),
		.kind     (kind_s2),
		.cnt      (cnt_s2),
		.pa       (a_s2),
		.pb       (b_s2),
		.pc       (c_s2),
		.pd       (d_s2),
		.pe       (e_s2),
		.pf       (f_s2),
		.hex_r    (hex_s2),
		.ctl      (ctl),
		.cand     (cand)
	);

	for (genvar i = 0; i < NUM_BOUNDS; i++) begin : g_box
		logic signed [COORD_WIDTH-1:0] base;
		logic signed [XW-1:0]          wide_nx;
		if (i % 2 == 0) begin : g_low
			assign base      = ctl.clear ? CMAX : box_q[i];
			assign box_nx[i] = (ctl.en[i] && cand[i] < base) ? cand[i] : base;
		end else begin : g_high
			assign base      = ctl.clear ? CMIN : box_q[i];
			assign box_nx[i] = (ctl.en[i] && cand[i] > base) ? cand[i] : base;
		end
		assign wide_nx = XW'(box_nx[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				box_q[i] <= (i % 2 == 0) ? CMAX : CMIN;
			end else if (adv) begin
				box_q[i] <= box_nx[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				res_q[i] <= wide_nx[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_q <= ctl.bad;
		end
	end

	assign out_valid = out_valid_q;
	assign low_x     = res_q[LX];
	assign high_x    = res_q[HX];
	assign low_y     = res_q[LY];
	assign high_y    = res_q[HY];
	assign low_z     = res_q[LZ];
	assign high_z    = res_q[HZ];
	assign bad_kind  = bad_q;

	a_bad_keeps_box: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl.bad |=> box_q[LX] == $past(box_q[LX]) && box_q[HX] == $past(box_q[HX])
			&& box_q[LY] == $past(box_q[LY]) && box_q[HY] == $past(box_q[HY])
			&& box_q[LZ] == $past(box_q[LZ]) && box_q[HZ] == $past(box_q[HZ]))
		else $error("box changed on an invalid kind");

	a_box_only_grows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !ctl.clear |=> box_q[LX] <= $past(box_q[LX]) && box_q[HX] >= $past(box_q[HX])
			&& box_q[LY] <= $past(box_q[LY]) && box_q[HY] >= $past(box_q[HY])
			&& box_q[LZ] <= $past(box_q[LZ]) && box_q[HZ] >= $past(box_q[HZ]))
		else $error("box shrank without a clear");

	a_bad_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.bad |-> ctl.en == '0 && !ctl.clear)
		else $error("invalid kind drives a bound update");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("update without a result");

endmodule

// File: sim/sbba_checker.sv
// Scoreboard for surface_bounding_box_accumulator: watches the request and result channels, keeps its own
// copy of the six box bounds and compares every returned box with the predicted one.
// Depends on sbba_pkg for widths, kind codes, the hexagon factor and the bound indexes.
module sbba_checker #(
	parameter int COORD_WIDTH = sbba_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                start_new,
	input  logic [sbba_pkg::KIND_W-1:0]         command,
	input  logic [sbba_pkg::CNT_W-1:0]          param_count,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_a,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_b,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_c,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_d,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_e,
	input  logic signed [sbba_pkg::PARAM_W-1:0] param_f,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [sbba_pkg::OUT_W-1:0]   low_x,
	input  logic signed [sbba_pkg::OUT_W-1:0]   high_x,
	input  logic signed [sbba_pkg::OUT_W-1:0]   low_y,
	input  logic signed [sbba_pkg::OUT_W-1:0]   high_y,
	input  logic signed [sbba_pkg::OUT_W-1:0]   low_z,
	input  logic signed [sbba_pkg::OUT_W-1:0]   high_z,
	input  logic                                bad_kind,
	output int                                  fail_count,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbba_pkg::*;

	typedef struct packed {
		logic                              bad;
		logic [NUM_BOUNDS-1:0][OUT_W-1:0]  bound;
	} box_rec_t;

	localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	longint   box [NUM_BOUNDS];
	box_rec_t box_due [$];
	string    bound_label [NUM_BOUNDS];

	function automatic longint clamp_coord(longint v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < COORD_MIN) return COORD_MIN;
		return v;
	endfunction

	function automatic void clear_box();
		box[LX] = COORD_MAX;
		box[LY] = COORD_MAX;
		box[LZ] = COORD_MAX;
		box[HX] = COORD_MIN;
		box[HY] = COORD_MIN;
		box[HZ] = COORD_MIN;
	endfunction

	function automatic void widen_low(int idx, longint v);
		longint s;
		s = clamp_coord(v);
		if (s < box[idx]) box[idx] = s;
	endfunction

	function automatic void widen_high(int idx, longint v);
		longint s;
		s = clamp_coord(v);
		if (s > box[idx]) box[idx] = s;
	endfunction

	// lo_idx names the low bound; the high bound of the same axis follows it
	function automatic void widen_span(int lo_idx, longint ctr, longint rad);
		widen_high(lo_idx + 1, ctr + rad);
		widen_low(lo_idx, ctr - rad);
	endfunction

	// r / sin60, rounded to nearest with ties away from zero
	function automatic longint hex_extent(longint r);
		longint unsigned mag;
		longint unsigned prod;
		mag  = (r < 0) ? longint'(0) - r : r;
		prod = (mag * longint'(HEX_K) + (longint'(1) << (HEX_SHIFT - 1))) >> HEX_SHIFT;
		return (r < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic box_rec_t apply_surface(logic fresh, logic [KIND_W-1:0] kind,
			logic [CNT_W-1:0] cnt, longint a, longint b, longint c, longint d,
			longint e, longint f);
		box_rec_t rec;
		logic     bad;
		bad = kind > KIND_GCROSS;
		if (!bad && fresh) clear_box();
		if (!bad) begin
			case (kind)
				KIND_CYL_Z: begin
					widen_span(LX, a, c);
					widen_span(LY, b, c);
					if (cnt == CAP_COUNT) begin
						widen_low(LZ, d);
						widen_high(HZ, e);
					end
				end
				KIND_CYL_X: begin
					widen_span(LY, a, c);
					widen_span(LZ, b, c);
					if (cnt == CAP_COUNT) begin
						widen_low(LX, d);
						widen_high(HX, e);
					end
				end
				KIND_CYL_Y: begin
					widen_span(LX, a, c);
					widen_span(LZ, b, c);
					if (cnt == CAP_COUNT) begin
						widen_low(LY, d);
						widen_high(HY, e);
					end
				end
				KIND_CROSS, KIND_PAD: begin
					widen_span(LX, a, d);
					widen_span(LY, b, d);
				end
				KIND_SPHERE: begin
					widen_span(LX, a, d);
					widen_span(LY, b, d);
					widen_span(LZ, c, d);
				end
				KIND_CUBOID, KIND_RECT: begin
					if (kind == KIND_CUBOID) begin
						widen_low(LZ, e);
						widen_high(HZ, f);
					end
					widen_low(LX, a);
					widen_high(HX, b);
					widen_low(LY, c);
					widen_high(HY, d);
				end
				KIND_HEX_Y, KIND_HPRISM_Y: begin
					widen_span(LX, a, hex_extent(c));
					widen_span(LY, b, c);
					if (kind == KIND_HPRISM_Y) begin
						widen_low(LZ, d);
						widen_high(HZ, e);
					end
				end
				KIND_HEX_X, KIND_HPRISM_X: begin
					widen_span(LY, a, hex_extent(c));
					widen_span(LX, b, c);
					if (kind == KIND_HPRISM_X) begin
						widen_low(LZ, d);
						widen_high(HZ, e);
					end
				end
				KIND_PLANE_X: widen_span(LX, a, 0);
				KIND_PLANE_Y: widen_span(LY, a, 0);
				KIND_PLANE_Z: widen_span(LZ, a, 0);
				KIND_CAPCONE_X: if (cnt == CAP_COUNT) begin
					if (e < 0) widen_high(HX, a);
					else widen_low(LX, a);
				end
				KIND_CAPCONE_Y: if (cnt == CAP_COUNT) begin
					if (e < 0) widen_high(HY, b);
					else widen_low(LY, b);
				end
				KIND_CAPCONE_Z: if (cnt == CAP_COUNT) begin
					if (e < 0) widen_high(HZ, c);
					else widen_low(LZ, c);
				end
				KIND_CONE: begin
					if (e > 0) widen_high(HZ, c + e);
					else widen_low(LZ, c + e);
				end
				KIND_INFINITE: clear_box();
				KIND_DODECA: begin
					widen_span(LX, a, c);
					widen_span(LY, b, (cnt == ALT_COUNT) ? d : c);
				end
				KIND_OCTAGON, KIND_GCROSS: begin
					widen_span(LX, a, c);
					widen_span(LY, b, c);
				end
				default: ;
			endcase
		end
		rec.bad = bad;
		for (int i = 0; i < NUM_BOUNDS; i++) rec.bound[i] = box[i][OUT_W-1:0];
		return rec;
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
		clear_box();
		bound_label[LX] = "low_x";
		bound_label[HX] = "high_x";
		bound_label[LY] = "low_y";
		bound_label[HY] = "high_y";
		bound_label[LZ] = "low_z";
		bound_label[HZ] = "high_z";
	end

	always @(posedge clk or negedge arst_n) begin
		box_rec_t seen;
		box_rec_t due;
		if (!arst_n) begin
			clear_box();
			box_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				seen = {bad_kind, high_z, low_z, high_y, low_y, high_x, low_x};
				if (box_due.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					fail_count++;
				end else begin
					due = box_due.pop_front();
					for (int i = 0; i < NUM_BOUNDS; i++) begin
						if (seen.bound[i] !== due.bound[i]) begin
							$display("%0t: %s expected %h got %h", $time, bound_label[i],
								due.bound[i], seen.bound[i]);
							fail_count++;
						end
					end
					if (seen.bad !== due.bad) begin
						$display("%0t: bad_kind expected %b got %b", $time, due.bad, seen.bad);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				box_due.push_back(apply_surface(start_new, command, param_count,
					param_a, param_b, param_c, param_d, param_e, param_f));
		end
		pending = box_due.size();
	end

endmodule

// File: sim/testbench.sv
// Top of the surface_bounding_box_accumulator bench: clock, reset, request and result side
// stimulus with random idling and back-pressure, and the verdict.
// Depends on sbba_pkg, the block itself and sbba_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sbba_pkg::*;

	localparam int RANDOM_ITEMS = 425;
	localparam int LONG_HOLD    = 60;
	localparam logic [KIND_W-1:0]  KIND_INVALID_HI = 5'd31;
	localparam logic [PARAM_W-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [PARAM_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [PARAM_W-1:0] Q_ONE = 32'h0001_0000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic start_new;
	logic [KIND_W-1:0] command;
	logic [CNT_W-1:0] param_count;
	logic signed [PARAM_W-1:0] param_a, param_b, param_c, param_d, param_e, param_f;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] low_x, high_x, low_y, high_y, low_z, high_z;
	logic bad_kind;
	int   fail_count;
	int   pending;

	bit calm;
	bit steady;
	bit hold_long;

	surface_bounding_box_accumulator u_dut (.*);

	sbba_checker u_chk (.*);

	always #5 clk = ~clk;

	// caller stands at a falling edge; returns at the falling edge after acceptance
	task automatic offer_surface(logic fresh, logic [KIND_W-1:0] kind, logic [CNT_W-1:0] cnt,
			logic [PARAM_W-1:0] a, logic [PARAM_W-1:0] b, logic [PARAM_W-1:0] c,
			logic [PARAM_W-1:0] d, logic [PARAM_W-1:0] e, logic [PARAM_W-1:0] f);
		start_new   <= fresh;
		command     <= kind;
		param_count <= cnt;
		param_a     <= a;
		param_b     <= b;
		param_c     <= c;
		param_d     <= d;
		param_e     <= e;
		param_f     <= f;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic sender_gap(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	function automatic logic [PARAM_W-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4: return $urandom();
			default: begin
				v = int'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
				return v;
			end
		endcase
	endfunction

	function automatic logic [PARAM_W-1:0] pick_radius();
		if ($urandom_range(0, 3) == 0) return pick_coord();
		return $urandom_range(0, 32'h0032_0000);
	endfunction

	// result side
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (calm || steady || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				@(negedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	// request side
	initial begin
		int  idle_mode;
		bit  in_hold;
		logic [KIND_W-1:0] kind;
		logic [CNT_W-1:0]  cnt;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		start_new   = 1'b0;
		command     = '0;
		param_count = '0;
		param_a     = '0;
		param_b     = '0;
		param_c     = '0;
		param_d     = '0;
		param_e     = '0;
		param_f     = '0;
		calm        = 1'b0;
		steady      = 1'b0;
		hold_long   = 1'b0;
		idle_mode   = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer_surface(1'b1, KIND_SPHERE, 3'd4, 0, 0, 0, Q_ONE, 0, 0);
		offer_surface(1'b0, KIND_CUBOID, 3'd6, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
		// sums past both ends saturate
		offer_surface(1'b1, KIND_SPHERE, 3'd4, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 0, 0);
		// negative radius only pulls in the opposite bounds
		offer_surface(1'b1, KIND_CYL_Z, CAP_COUNT, Q_ONE, -32'sh2_0000, -32'sh8000,
			-32'sh3_0000, 32'sh4_0000, 0);
		offer_surface(1'b0, KIND_CYL_X, 3'd3, 32'sh5_0000, -32'sh5_0000, Q_ONE, Q_MIN, Q_MAX,
			0);
		offer_surface(1'b0, KIND_CYL_Y, CAP_COUNT, -32'sh7_0000, Q_ONE, 32'sh1_8000,
			-32'sh9_0000, 32'sh9_0000, 0);
		offer_surface(1'b0, KIND_CROSS, 3'd4, 32'sh2_0000, 32'sh3_0000, 0, 32'sh10_0000, 0, 0);
		offer_surface(1'b1, KIND_RECT, 3'd4, -32'sh1_0000, Q_ONE, -32'sh2_0000, 32'sh2_0000,
			0, 0);
		offer_surface(1'b0, KIND_HEX_Y, 3'd3, 0, 0, Q_MIN, 0, 0, 0);
		offer_surface(1'b1, KIND_HEX_X, 3'd3, Q_ONE, 0, -32'sh3_0000, 0, 0, 0);
		offer_surface(1'b0, KIND_HPRISM_Y, CAP_COUNT, 32'sh4_0000, Q_ONE, 32'sh2_0001,
			-32'sh6_0000, 32'sh6_0000, 0);
		offer_surface(1'b0, KIND_HPRISM_X, 3'd5, -32'sh4_0000, Q_ONE, 32'sh0_0003,
			Q_MIN, Q_MAX, 0);
		offer_surface(1'b1, KIND_PLANE_X, 3'd1, Q_MIN, 0, 0, 0, 0, 0);
		offer_surface(1'b0, KIND_PLANE_Y, 3'd1, 32'sh7_0000, 0, 0, 0, 0, 0);
		offer_surface(1'b0, KIND_PLANE_Z, 3'd1, Q_MAX, 0, 0, 0, 0, 0);
		offer_surface(1'b0, KIND_CAPCONE_X, CAP_COUNT, 32'sh9_0000, 0, 0, 0, -32'sh1, 0);
		offer_surface(1'b0, KIND_CAPCONE_Y, CAP_COUNT, 0, -32'sh9_0000, 0, 0, 0, 0);
		offer_surface(1'b0, KIND_CAPCONE_Z, ALT_COUNT, 0, 0, Q_MIN, 0, -32'sh1, 0);
		offer_surface(1'b1, KIND_CONE, 3'd5, 0, 0, Q_MAX, 0, Q_MAX, 0);
		offer_surface(1'b0, KIND_CONE, 3'd5, 0, 0, -32'sh7_0000, 0, 0, 0);
		offer_surface(1'b0, KIND_PAD, 3'd4, 32'sh1_0000, 32'sh1_0000, 0, 32'sh20_0000, 0, 0);
		offer_surface(1'b1, KIND_DODECA, ALT_COUNT, 0, 0, Q_ONE, 32'sh5_0000, 0, 0);
		offer_surface(1'b0, KIND_OCTAGON, 3'd3, 32'sh8_0000, -32'sh8_0000, Q_ONE, 0, 0, 0);
		offer_surface(1'b0, KIND_UNBOUNDED, 3'd6, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		offer_surface(1'b0, KIND_GCROSS, 3'd3, -32'sh8_0000, 32'sh8_0000, 32'sh2_0000, 0, 0,
			0);
		// invalid kind leaves the box alone, start_new too
		offer_surface(1'b1, KIND_INVALID_HI, 3'd6, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		offer_surface(1'b0, KIND_INFINITE, 3'd0, 0, 0, 0, 0, 0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) idle_mode = $urandom_range(0, 2);
			steady  = (idle_mode == 0);
			calm    = (n >= RANDOM_ITEMS - 60);
			in_hold = (n >= 150 && n < 190);
			if (n == 150) hold_long = 1'b1;
			if (n == 300) begin
				sender_gap(1);
				while (pending != 0) @(negedge clk);
			end
			if (!calm && !in_hold && idle_mode != 0 &&
					$urandom_range(0, (idle_mode == 1) ? 7 : 2) == 0)
				sender_gap($urandom_range(1, 8));
			if ($urandom_range(0, 99) < 5)
				kind = KIND_W'($urandom_range(KIND_GCROSS + 1, KIND_INVALID_HI));
			else
				kind = KIND_W'($urandom_range(0, KIND_GCROSS));
			if ($urandom_range(0, 2) == 0) cnt = CNT_W'($urandom_range(0, 6));
			else cnt = $urandom_range(0, 1) ? CAP_COUNT : ALT_COUNT;
			offer_surface($urandom_range(0, 7) == 0, kind, cnt, pick_coord(), pick_coord(),
				pick_radius(), pick_radius(), pick_coord(), pick_coord());
		end

		sender_gap(1);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
